>>> src/ccsm_pkg.sv
// Shared types, character codes and scan mode codes for the comment and string masker.
package ccsm_pkg;

	localparam int OBUF_DEPTH_DEF = 4;

	localparam logic [2:0] MODE_PLAIN = 3'd0;
	localparam logic [2:0] MODE_SLASH = 3'd1;
	localparam logic [2:0] MODE_LINE  = 3'd2;
	localparam logic [2:0] MODE_BLOCK = 3'd3;
	localparam logic [2:0] MODE_QUOTE = 3'd4;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	typedef struct packed {
		logic [2:0] mode;
		logic       quote_sq;
		logic       star;
		logic       esc;
	} scan_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} result_t;

endpackage

>>> src/c_comment_string_masker.sv
// Top level of the C comment and string literal masker.
//
// The block takes C source one byte per transfer on the s_ side and returns masked
// bytes on the m_ side: bytes of line comments, block comments and quoted literals,
// delimiters included, come out as spaces, everything else (and every newline) passes
// unchanged. A '/' in plain code is held until the next byte arrives, so one input
// transfer gives zero, one or two output transfers; m_tlast marks the last output
// caused by each input. A held slash at the end of the stream is released only by a
// further byte. The block accepts one byte per cycle whenever the output side is ready.
// A byte that releases a held slash gives two results, but the slash itself gave none,
// so results never outrun the one transfer per cycle of the output port; only output
// back-pressure stalls the input. From input to output a byte passes an input
// register, then the scan logic, which writes a four-entry result queue whose head
// drives the output.
// The scan state (mode, quote kind, pending star, pending escape) is a single register
// updated as each byte leaves the input register, so it waits for room in the queue.
module c_comment_string_masker
	import ccsm_pkg::*;
#(
	parameter int OBUF_DEPTH = OBUF_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // src_byte [7:0]
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // masked_byte [7:0]
	output logic       m_tlast    // last_of_run
);

	// Input register.
	logic        valid_s1;
	logic [7:0]  data_s1;

	// Scan state carried from byte to byte.
	scan_state_t state_q;
	scan_state_t state_d;

	logic [1:0]  res_n;
	result_t     res0;
	result_t     res1;
	logic        room2;
	logic        advance;
	logic [1:0]  push_n;

	// A byte leaves the input register once the queue can take two results.
	assign advance  = valid_s1 && room2;
	assign s_tready = !valid_s1 || advance;
	assign push_n   = advance ? res_n : 2'd0;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '{mode: MODE_PLAIN, quote_sq: 1'b0, star: 1'b0, esc: 1'b0};
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				state_q <= state_d;
			end
		end
	end

	ccsm_scan u_scan (
		.data  (data_s1),
		.st    (state_q),
		.nxt   (state_d),
		.res_n (res_n),
		.res0  (res0),
		.res1  (res1)
	);

	ccsm_obuf #(
		.DEPTH (OBUF_DEPTH)
	) u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.d0       (res0),
		.d1       (res1),
		.room2    (room2),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// A stalled byte stays in the input register.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(data_s1)))
		else $error("input register lost a stalled byte");

	// A newline clears the pending star and escape.
	a_nl_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && data_s1 == CH_NL) |=> (!state_q.star && !state_q.esc))
		else $error("newline left star or escape pending");

	// Only a held slash may be followed by a byte that gives two results.
	a_two_needs_slash: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_n == 2'd2) |-> (state_q.mode == MODE_SLASH))
		else $error("two results without a held slash");

endmodule

>>> src/ccsm_scan.sv
// Next-state and result logic for one source byte of the masker.
module ccsm_scan
	import ccsm_pkg::*;
(
	input  logic [7:0]  data,
	input  scan_state_t st,
	output scan_state_t nxt,
	output logic [1:0]  res_n,
	output result_t     res0,
	output result_t     res1
);

	// Treatment of a byte met in plain code.
	logic       p_emit;
	logic [7:0] p_data;
	logic [2:0] p_mode;
	logic       p_quote;

	always_comb begin
		p_emit  = 1'b1;
		p_data  = data;
		p_mode  = MODE_PLAIN;
		p_quote = 1'b0;
		if (data == CH_SLASH) begin
			p_emit = 1'b0;
			p_mode = MODE_SLASH;
		end else if (data == CH_DQ || data == CH_SQ) begin
			p_data  = CH_SPACE;
			p_mode  = MODE_QUOTE;
			p_quote = 1'b1;
		end
	end

	logic [7:0] d0;
	logic [7:0] d1;

	always_comb begin
		nxt   = st;
		res_n = 2'd0;
		d0    = CH_SPACE;
		d1    = CH_SPACE;
		if (data == CH_NL) begin
			if (st.mode == MODE_SLASH) begin
				res_n = 2'd2;
				d0    = CH_SLASH;
				d1    = CH_NL;
			end else begin
				res_n = 2'd1;
				d0    = CH_NL;
			end
			if (st.mode != MODE_BLOCK) begin
				nxt.mode = MODE_PLAIN;
			end
			nxt.star = 1'b0;
			nxt.esc  = 1'b0;
		end else begin
			unique case (st.mode)
				MODE_SLASH: begin
					if (data == CH_SLASH) begin
						res_n    = 2'd2;
						nxt.mode = MODE_LINE;
					end else if (data == CH_STAR) begin
						res_n    = 2'd2;
						nxt.mode = MODE_BLOCK;
						nxt.star = 1'b0;
					end else begin
						d0       = CH_SLASH;
						d1       = p_data;
						res_n    = p_emit ? 2'd2 : 2'd1;
						nxt.mode = p_mode;
						if (p_quote) begin
							nxt.quote_sq = (data == CH_SQ);
							nxt.esc      = 1'b0;
						end
					end
				end
				MODE_LINE: begin
					res_n = 2'd1;
				end
				MODE_BLOCK: begin
					res_n = 2'd1;
					if (data == CH_SLASH && st.star) begin
						nxt.mode = MODE_PLAIN;
						nxt.star = 1'b0;
					end else begin
						nxt.star = (data == CH_STAR);
					end
				end
				MODE_QUOTE: begin
					res_n = 2'd1;
					if (st.esc) begin
						nxt.esc = 1'b0;
					end else if (data == CH_BSL) begin
						nxt.esc = 1'b1;
					end else if (data == (st.quote_sq ? CH_SQ : CH_DQ)) begin
						nxt.mode = MODE_PLAIN;
					end
				end
				default: begin
					d0       = p_data;
					res_n    = p_emit ? 2'd1 : 2'd0;
					nxt.mode = p_mode;
					if (p_quote) begin
						nxt.quote_sq = (data == CH_SQ);
						nxt.esc      = 1'b0;
					end
				end
			endcase
		end
	end

	assign res0.data = d0;
	assign res0.last = (res_n == 2'd1);
	assign res1.data = d1;
	assign res1.last = 1'b1;

endmodule

>>> src/ccsm_obuf.sv
// Queue that takes up to two results a cycle and sends one a cycle when m_tready.
module ccsm_obuf
	import ccsm_pkg::*;
#(
	parameter int DEPTH = OBUF_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  result_t    d0,
	input  result_t    d1,
	output logic       room2,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // masked_byte [7:0]
	output logic       m_tlast
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] ROOM_CNT = CW'(DEPTH - 2);

	result_t       mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	logic [PW-1:0] wr1;
	logic [PW-1:0] wr2;
	logic [PW-1:0] rd1;
	logic          pop;

	assign wr1 = (wr_q == LAST_IDX) ? '0 : wr_q + 1'b1;
	assign wr2 = (wr1 == LAST_IDX) ? '0 : wr1 + 1'b1;
	assign rd1 = (rd_q == LAST_IDX) ? '0 : rd_q + 1'b1;

	assign m_tvalid = (cnt_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign room2    = (cnt_q <= ROOM_CNT);
	assign m_tdata  = mem_q[rd_q].data;
	assign m_tlast  = mem_q[rd_q].last;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= d0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr1] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			unique case (push_n)
				2'd1:    wr_q <= wr1;
				2'd2:    wr_q <= wr2;
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= rd1;
			end
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

	// The queue never overflows and never takes the unused push count.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("result queue count beyond its depth");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> (room2 && push_n != 2'd3))
		else $error("results pushed without room for two");

endmodule
